### sv/k_way_sorted_merge_assert.svh
// assertion macros shared by the merge block
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define KWM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define KWM_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define KWM_ASSERT(label, clk, rst, prop, msg)
`define KWM_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### sv/kwm_pkg.sv
// types, sizes and helpers of the k-way merge block
package kwm_pkg;

   localparam int NUM_LISTS  = 8;
   localparam int LIST_DEPTH = 8;

   localparam int LIST_W = $clog2(NUM_LISTS);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_LISTS * LIST_DEPTH);
   localparam int TOT_W  = $clog2(NUM_LISTS * LIST_DEPTH + 1);
   localparam int NUM_LEAF = 2 ** LIST_W;
   localparam int NUM_PAIR = NUM_LEAF / 2;

   typedef logic [LIST_W-1:0] list_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [TOT_W-1:0]  tot_type;
   typedef logic signed [31:0] value_type;

   // one candidate head in the selection tree
   typedef struct packed {
      logic      ok;
      list_type  idx;
      value_type val;
   } node_type;

   // head register updates from the sequencer
   typedef struct packed {
      logic      wr;
      list_type  wr_tag;
      value_type wr_data;
      logic      kill;
      list_type  kill_tag;
   } head_wr_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_INIT,
      ST_REFILL,
      ST_SEL
   } state_type;

   // store address of element pos of list k
   function automatic addr_type addr_of(list_type k, cnt_type pos);
      return addr_type'(int'(k) * LIST_DEPTH + int'(pos));
   endfunction

endpackage

### sv/kwm_if.sv
// request and response channel interfaces of the merge block
interface kwm_req_if;
   import kwm_pkg::*;
   logic       valid;
   logic       ready;
   logic [2:0] list_index;
   value_type  value;
   logic       has_value;
   logic       end_of_load;

   modport source (output valid, list_index, value, has_value, end_of_load, input ready);
   modport sink   (input valid, list_index, value, has_value, end_of_load, output ready);
endinterface

interface kwm_rsp_if;
   import kwm_pkg::*;
   logic       valid;
   logic       ready;
   value_type  merged_value;
   logic [2:0] source_list;
   logic       last_result;
   logic       overflow;

   modport source (output valid, merged_value, source_list, last_result, overflow,
                   input ready);
   modport sink   (input valid, merged_value, source_list, last_result, overflow,
                   output ready);
endinterface

### sv/k_way_sorted_merge.sv
// k-way merge of up to eight sorted lists held in an element store
// usage: elements arrive on req, each tagged with its list number, and are
//   appended to that list in arrival order, one transaction per cycle.
//   a transaction with has_value low carries no element; end_of_load marks
//   the last transaction of a data set (its element, if any, is loaded first)
// merge: after end_of_load of a non-empty data set req.ready drops; the first
//   element of every non-empty list is fetched from the store (ST_INIT visits
//   every list, one read per non-empty list); per result, ST_SEL picks the
//   smallest head from the selection tree and issues the ram read of that
//   list's next element, and ST_REFILL writes the read data into its head.
//   ties go to the lower list number. the final result carries last_result
// overflow: set on every result of a data set in which an element was
//   dropped (list full or list number out of range)
// an empty data set gives no result and clears the drop flag
// stall: the response register holds its transaction while rsp.ready is low
//   and the merge waits; loading of the next data set may start while the
//   last result still waits to be taken
// reset: fill counts, read positions, drop flag and control clear at once;
//   the store itself is not cleared, only entries below a fill are read
`include "k_way_sorted_merge_assert.svh"

module k_way_sorted_merge (
   input logic   clock,
   input logic   reset,
   kwm_req_if.sink   req,
   kwm_rsp_if.source rsp
);
   import kwm_pkg::*;

   state_type   state_ff, state_in;
   cnt_type     fill_ff [NUM_LISTS];
   cnt_type     fill_in [NUM_LISTS];
   cnt_type     rpos_ff [NUM_LISTS];
   cnt_type     rpos_in [NUM_LISTS];
   tot_type     total_ff, total_in;
   tot_type     remain_ff, remain_in;
   logic        dropped_ff, dropped_in;
   list_type    init_k_ff, init_k_in;
   logic        rd_vld_ff, rd_vld_in;
   list_type    rd_tag_ff, rd_tag_in;
   logic        rsp_valid_ff, rsp_valid_in;
   value_type   rsp_value_ff, rsp_value_in;
   logic [2:0]  rsp_src_ff, rsp_src_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_ovf_ff, rsp_ovf_in;

   // store ports
   logic        ram_wr_en;
   addr_type    ram_wr_addr;
   logic        ram_rd_en;
   addr_type    ram_rd_addr;
   logic [31:0] ram_rd_data;

   head_wr_type head_ctl;
   node_type    pick;
   logic        kill;
   list_type    req_list;
   logic        req_idx_ok;
   list_type    fsel;
   cnt_type     fill_sel;
   cnt_type     rpos_nxt;
   tot_type     tot_nxt;
   logic        loaded;
   logic        slot_free;

   kwm_ram #(
      .WIDTH (32),
      .DEPTH (NUM_LISTS * LIST_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req.value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ram data lands in the head of the list it was read for
   assign head_ctl.wr       = rd_vld_ff;
   assign head_ctl.wr_tag   = rd_tag_ff;
   assign head_ctl.wr_data  = value_type'(ram_rd_data);
   assign head_ctl.kill     = kill;
   assign head_ctl.kill_tag = pick.idx;

   kwm_heads u_heads (
      .clock (clock),
      .reset (reset),
      .ctl   (head_ctl),
      .pick  (pick)
   );

   assign req_list   = LIST_W'(req.list_index);
   assign req_idx_ok = (int'(req.list_index) < NUM_LISTS);
   assign slot_free  = !rsp_valid_ff || rsp.ready;

   // single read point into the fill counts
   assign fsel     = (state_ff == ST_LOAD) ? req_list :
                     (state_ff == ST_INIT) ? init_k_ff : pick.idx;
   assign fill_sel = fill_ff[fsel];
   assign rpos_nxt = rpos_ff[pick.idx] + CNT_W'(1);

   assign req.ready = (state_ff == ST_LOAD);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rpos_in      = rpos_ff;
      total_in     = total_ff;
      remain_in    = remain_ff;
      dropped_in   = dropped_ff;
      init_k_in    = init_k_ff;
      rd_vld_in    = 1'b0;
      rd_tag_in    = rd_tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_of(req_list, fill_sel);
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_of(pick.idx, rpos_nxt);
      kill         = 1'b0;
      loaded       = 1'b0;
      tot_nxt      = total_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req.valid) begin
               if (req.has_value) begin
                  if (req_idx_ok && (fill_sel < CNT_W'(LIST_DEPTH))) begin
                     ram_wr_en         = 1'b1;
                     fill_in[req_list] = fill_sel + CNT_W'(1);
                     loaded            = 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
               end
               tot_nxt  = total_ff + TOT_W'(loaded);
               total_in = tot_nxt;
               if (req.end_of_load) begin
                  if (tot_nxt == '0) begin
                     // nothing stored: no result, drop flag forgotten
                     dropped_in = 1'b0;
                  end else begin
                     state_in  = ST_INIT;
                     init_k_in = '0;
                     remain_in = tot_nxt;
                  end
               end
            end
         end
         ST_INIT: begin
            // fetch the first element of each non-empty list
            if (fill_sel != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = addr_of(init_k_ff, '0);
               rd_vld_in   = 1'b1;
               rd_tag_in   = init_k_ff;
            end
            if (init_k_ff == LIST_W'(NUM_LISTS - 1)) begin
               state_in = ST_REFILL;
            end else begin
               init_k_in = init_k_ff + LIST_W'(1);
            end
         end
         ST_REFILL: begin
            // read data enters the heads, first tree level re-registers
            state_in = ST_SEL;
         end
         ST_SEL: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_value_in      = pick.val;
               rsp_src_in        = 3'(pick.idx);
               rsp_last_in       = (remain_ff == TOT_W'(1));
               rsp_ovf_in        = dropped_ff;
               remain_in         = remain_ff - TOT_W'(1);
               rpos_in[pick.idx] = rpos_nxt;
               if (rpos_nxt < fill_sel) begin
                  ram_rd_en = 1'b1;
                  rd_vld_in = 1'b1;
                  rd_tag_in = pick.idx;
               end else begin
                  kill = 1'b1;
               end
               if (remain_ff == TOT_W'(1)) begin
                  // run complete: empty the lists for the next data set
                  for (int k = 0; k < NUM_LISTS; k++) begin
                     fill_in[k] = '0;
                     rpos_in[k] = '0;
                  end
                  total_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  state_in = ST_REFILL;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         for (int k = 0; k < NUM_LISTS; k++) begin
            fill_ff[k] <= '0;
            rpos_ff[k] <= '0;
         end
         total_ff     <= '0;
         remain_ff    <= '0;
         dropped_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rpos_ff      <= rpos_in;
         total_ff     <= total_in;
         remain_ff    <= remain_in;
         dropped_ff   <= dropped_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      init_k_ff    <= init_k_in;
      rd_tag_ff    <= rd_tag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_src_ff   <= rsp_src_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.merged_value = rsp_value_ff;
   assign rsp.source_list  = rsp_src_ff;
   assign rsp.last_result  = rsp_last_ff;
   assign rsp.overflow     = rsp_ovf_ff;

   // a merge step always finds a live head while results remain
   `KWM_ASSERT(a_sel_has_head, clock, reset, (state_ff == ST_SEL) |-> pick.ok, "merge step without a live head")
   // the final result closes the run and is presented marked
   `KWM_ASSERT(a_last_ends_run, clock, reset, ((state_ff == ST_SEL) && slot_free && (remain_ff == TOT_W'(1))) |=> ((state_ff == ST_LOAD) && rsp_valid_ff && rsp_last_ff), "final result did not end the run")
   // no results outstanding while loading
   `KWM_ASSERT(a_load_no_remain, clock, reset, (state_ff == ST_LOAD) |-> (remain_ff == '0), "results outstanding in load phase")
   // no store read in flight once the run has ended
   `KWM_ASSERT_NEVER(a_no_read_in_load, clock, reset, (state_ff == ST_LOAD) && rd_vld_ff, "store read in flight during load")

endmodule

### sv/kwm_ram.sv
// simple dual-port ram, one write and one registered read port
module kwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/kwm_heads.sv
// head registers of every list and the smallest-head selection tree
module kwm_heads (
   input  logic                 clock,
   input  logic                 reset,
   input  kwm_pkg::head_wr_type ctl,
   output kwm_pkg::node_type    pick
);
   import kwm_pkg::*;

   value_type head_val_ff [NUM_LISTS];
   value_type head_val_in [NUM_LISTS];
   logic      head_ok_ff  [NUM_LISTS];
   logic      head_ok_in  [NUM_LISTS];
   node_type  leaf        [NUM_LEAF];
   node_type  pair_ff     [NUM_PAIR];
   node_type  pair_in     [NUM_PAIR];

   // lower list wins a tie
   function automatic node_type best2(node_type a, node_type b);
      if (b.ok && (!a.ok || ($signed(b.val) < $signed(a.val)))) begin
         return b;
      end
      return a;
   endfunction

   always_comb begin
      for (int k = 0; k < NUM_LISTS; k++) begin
         head_val_in[k] = head_val_ff[k];
         head_ok_in[k]  = head_ok_ff[k];
         if (ctl.wr && (ctl.wr_tag == LIST_W'(k))) begin
            head_val_in[k] = ctl.wr_data;
            head_ok_in[k]  = 1'b1;
         end
         if (ctl.kill && (ctl.kill_tag == LIST_W'(k))) begin
            head_ok_in[k] = 1'b0;
         end
      end
   end

   // first tree level works on the next head values
   always_comb begin
      for (int i = 0; i < NUM_LISTS; i++) begin
         leaf[i].ok  = head_ok_in[i];
         leaf[i].idx = LIST_W'(i);
         leaf[i].val = head_val_in[i];
      end
      for (int i = NUM_LISTS; i < NUM_LEAF; i++) begin
         leaf[i] = '0;
      end
      for (int j = 0; j < NUM_PAIR; j++) begin
         pair_in[j] = best2(leaf[2*j], leaf[2*j+1]);
      end
   end

   // remaining levels over the registered pairs
   always_comb begin
      node_type t [NUM_PAIR];
      t = pair_ff;
      for (int s = NUM_PAIR / 2; s >= 1; s = s >> 1) begin
         for (int i = 0; i < s; i++) begin
            t[i] = best2(t[2*i], t[2*i+1]);
         end
      end
      pick = t[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_LISTS; k++) begin
            head_ok_ff[k] <= 1'b0;
         end
      end else begin
         head_ok_ff <= head_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      head_val_ff <= head_val_in;
      pair_ff     <= pair_in;
   end

endmodule
